// ===== rtl/core/tsr_pkg.sv =====
// Shared types and constants for the timed sequence release block.
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    // Default table depth and per-tick release bound.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MAX_RELEASE_DEF = 16;

    // A single tick never delivers more than this many results.
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = 5;

    // Field widths fixed by the interface.
    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int HANDLE_W   = 16;
    localparam int DELAY_W    = 32;
    localparam int CFG_REG_W  = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT = 8'd1;

    localparam logic [CFG_REG_W-1:0] RELEASE_LIMIT_RST = 5'd16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD     = 2'd1,
        OP_ACTIVATE = 2'd2,
        OP_ABORT    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic scan_commit;
        logic emit_load;
        logic emit_marker;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_run;
        logic scan_stop;
        logic emit_none;
        logic emit_last;
        logic ended;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsr_ctrl.sv =====
// Controller state machine for the timed sequence release block.
`timescale 1ns / 1ps
`default_nettype none

module tsr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  tsr_pkg::dp_status_t     status,
    output tsr_pkg::ctrl_cmd_t      cmd
);

    tsr_pkg::state_t state_reg;
    tsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (in_valid && status.tick_run)
                begin
                    state_next = tsr_pkg::ST_SCAN;
                end
            end
            tsr_pkg::ST_SCAN:
            begin
                if (status.scan_stop)
                begin
                    state_next = tsr_pkg::ST_EMIT;
                end
            end
            tsr_pkg::ST_EMIT:
            begin
                if (status.emit_none)
                begin
                    if (!status.ended || status.out_free)
                    begin
                        state_next = tsr_pkg::ST_IDLE;
                    end
                end
                else if (status.out_free && status.emit_last)
                begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.scan_step   = 1'b0;
        cmd.scan_commit = 1'b0;
        cmd.emit_load   = 1'b0;
        cmd.emit_marker = 1'b0;
        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            tsr_pkg::ST_SCAN:
            begin
                cmd.scan_step   = !status.scan_stop;
                cmd.scan_commit = status.scan_stop;
            end
            tsr_pkg::ST_EMIT:
            begin
                cmd.emit_load   = !status.emit_none && status.out_free;
                cmd.emit_marker = status.emit_none && status.ended && status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsr_datapath.sv =====
// Datapath of the timed sequence release block: tables, run state and output register.
`timescale 1ns / 1ps
`default_nettype none

module tsr_datapath #(
    parameter int MAX_ENTRIES = tsr_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_RELEASE = tsr_pkg::MAX_RELEASE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  tsr_pkg::ctrl_cmd_t                      cmd,
    output tsr_pkg::dp_status_t                     status,
    input  wire logic [tsr_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic [tsr_pkg::INDEX_W-1:0]        entry_index,
    input  wire logic [tsr_pkg::HANDLE_W-1:0]       request_handle,
    input  wire logic [tsr_pkg::DELAY_W-1:0]        delay_ticks,
    input  wire logic                               cfg_we,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [tsr_pkg::HANDLE_W-1:0]            released_handle,
    output logic [tsr_pkg::INDEX_W-1:0]             released_index,
    output logic                                    last,
    output logic                                    sequence_done
);

    localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_MAX = (MAX_RELEASE < tsr_pkg::RESULT_CAP) ? MAX_RELEASE
                                                                 : tsr_pkg::RESULT_CAP;

    // Tables, read together at one address every cycle.
    logic [tsr_pkg::HANDLE_W-1:0] handle_mem [MAX_ENTRIES];
    logic [tsr_pkg::DELAY_W-1:0]  delay_mem  [MAX_ENTRIES];
    logic [tsr_pkg::HANDLE_W-1:0] handle_rd_reg;
    logic [tsr_pkg::DELAY_W-1:0]  delay_rd_reg;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         wr_en;

    // Run state and configuration.
    logic [CW-1:0]                next_entry_reg, next_entry_next;
    logic [tsr_pkg::DELAY_W-1:0]  countdown_reg, countdown_next;
    logic                         executing_reg, executing_next;
    logic [tsr_pkg::CFG_REG_W-1:0] entry_count_reg;
    logic [tsr_pkg::CFG_REG_W-1:0] release_limit_reg;

    // Working registers of one tick.
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                start_reg;
    logic [tsr_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tsr_pkg::CNT_W-1:0]    total_reg;
    logic                         ended_reg;
    logic [tsr_pkg::DELAY_W-1:0]  scan_cd_reg;

    logic                         out_valid_reg;
    logic [tsr_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [tsr_pkg::INDEX_W-1:0]  out_index_reg;
    logic                         out_last_reg;
    logic                         out_done_reg;

    logic [CW-1:0]                count;
    logic [tsr_pkg::CNT_W-1:0]    limit;
    logic                         cd_zero;
    logic                         at_end;
    logic                         at_limit;
    logic                         scan_ended;
    logic                         is_tick;
    logic                         is_load;
    logic                         is_activate;
    logic                         is_abort;

    always_comb
    begin
        if (32'(entry_count_reg) > MAX_ENTRIES)
        begin
            count = CW'(MAX_ENTRIES);
        end
        else
        begin
            count = CW'(entry_count_reg);
        end
        if (32'(release_limit_reg) > LIM_MAX)
        begin
            limit = tsr_pkg::CNT_W'(LIM_MAX);
        end
        else
        begin
            limit = release_limit_reg;
        end
    end

    assign is_tick     = (opcode == tsr_pkg::OP_TICK);
    assign is_load     = (opcode == tsr_pkg::OP_LOAD);
    assign is_activate = (opcode == tsr_pkg::OP_ACTIVATE);
    assign is_abort    = (opcode == tsr_pkg::OP_ABORT);

    assign cd_zero    = (scan_cd_reg == '0);
    assign at_end     = (ptr_reg >= count);
    assign at_limit   = (cnt_reg >= limit);
    assign scan_ended = cd_zero && at_end;

    assign status.tick_run  = is_tick && executing_reg;
    assign status.scan_stop = !cd_zero || at_end || at_limit;
    assign status.emit_none = (total_reg == '0);
    assign status.emit_last = (cnt_reg == total_reg - tsr_pkg::CNT_W'(1));
    assign status.ended     = ended_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign wr_en   = cmd.accept && is_load && (32'(entry_index) < MAX_ENTRIES);
    assign wr_addr = AW'(entry_index);
    assign rd_addr = AW'(ptr_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_mem[wr_addr] <= request_handle;
            delay_mem[wr_addr]  <= delay_ticks;
        end
        handle_rd_reg <= handle_mem[rd_addr];
        delay_rd_reg  <= delay_mem[rd_addr];
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        priority if (cmd.accept && status.tick_run)
        begin
            ptr_next = next_entry_reg;
            cnt_next = '0;
        end
        else if (cmd.scan_step || cmd.emit_load)
        begin
            ptr_next = ptr_reg + CW'(1);
            cnt_next = cnt_reg + tsr_pkg::CNT_W'(1);
        end
        else if (cmd.scan_commit)
        begin
            ptr_next = start_reg;
            cnt_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg;
            cnt_next = cnt_reg;
        end
    end

    always_comb
    begin
        next_entry_next = next_entry_reg;
        countdown_next  = countdown_reg;
        executing_next  = executing_reg;
        if (cmd.accept && is_activate)
        begin
            next_entry_next = '0;
            countdown_next  = '0;
            executing_next  = 1'b1;
        end
        else if (cmd.accept && is_abort)
        begin
            next_entry_next = '0;
            countdown_next  = '0;
            executing_next  = 1'b0;
        end
        else if (cmd.scan_commit)
        begin
            if (scan_ended)
            begin
                next_entry_next = '0;
                countdown_next  = '0;
                executing_next  = 1'b0;
            end
            else
            begin
                next_entry_next = ptr_reg;
                countdown_next  = cd_zero ? scan_cd_reg
                                          : scan_cd_reg - tsr_pkg::DELAY_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_entry_reg    <= '0;
            countdown_reg     <= '0;
            executing_reg     <= 1'b0;
            entry_count_reg   <= '0;
            release_limit_reg <= tsr_pkg::RELEASE_LIMIT_RST;
            ptr_reg           <= '0;
            start_reg         <= '0;
            cnt_reg           <= '0;
            total_reg         <= '0;
            ended_reg         <= 1'b0;
            scan_cd_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            next_entry_reg <= next_entry_next;
            countdown_reg  <= countdown_next;
            executing_reg  <= executing_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;

            if (cfg_we && cfg_index == tsr_pkg::REG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg_data[tsr_pkg::CFG_REG_W-1:0];
            end
            if (cfg_we && cfg_index == tsr_pkg::REG_RELEASE_LIMIT)
            begin
                release_limit_reg <= cfg_data[tsr_pkg::CFG_REG_W-1:0];
            end

            if (cmd.accept && status.tick_run)
            begin
                start_reg   <= next_entry_reg;
                scan_cd_reg <= countdown_reg;
            end
            else if (cmd.scan_step)
            begin
                scan_cd_reg <= delay_rd_reg;
            end

            if (cmd.scan_commit)
            begin
                total_reg <= cnt_reg;
                ended_reg <= scan_ended;
            end

            if (cmd.emit_load || cmd.emit_marker)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_handle_reg <= handle_rd_reg;
            out_index_reg  <= tsr_pkg::INDEX_W'(ptr_reg);
            out_last_reg   <= status.emit_last;
            out_done_reg   <= ended_reg;
        end
        else if (cmd.emit_marker)
        begin
            out_handle_reg <= '0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign released_handle = out_handle_reg;
    assign released_index  = out_index_reg;
    assign last            = out_last_reg;
    assign sequence_done   = out_done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/timed_sequence_release.sv =====
// Top level of the timed sequence release block.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Contents
// input     in         in_valid / in_ready   opcode, entry_index, request_handle,
//                                            delay_ticks
// output    out        out_valid / out_ready released_handle, released_index,
//                                            last, sequence_done
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load, activate, abort and a tick while not executing finish at their transfer.
// A tick while executing runs a scan pass and then an emit pass: the scan pass
// walks the delay table one entry per cycle to find how many entries go out
// and whether the table runs out, then the emit pass reads the handles one per
// cycle while the output is free, or sends just an end marker when nothing goes
// out and the run ended. Both passes share the single read port of the tables.
// The output register lets the next transfer be accepted while the last
// result of a tick still waits; a stalled output only holds up the emit pass.
// Reset clears the run state and the entry count and sets the release limit to 16
// at once; the tables hold undefined data until loaded, so there is no clearing pass.

module timed_sequence_release #(
    parameter int MAX_ENTRIES = tsr_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_RELEASE = tsr_pkg::MAX_RELEASE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tsr_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic [tsr_pkg::INDEX_W-1:0]        entry_index,
    input  wire logic [tsr_pkg::HANDLE_W-1:0]       request_handle,
    input  wire logic [tsr_pkg::DELAY_W-1:0]        delay_ticks,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [tsr_pkg::HANDLE_W-1:0]            released_handle,
    output logic [tsr_pkg::INDEX_W-1:0]             released_index,
    output logic                                    last,
    output logic                                    sequence_done,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tsr_pkg::ctrl_cmd_t  cmd;
    tsr_pkg::dp_status_t status;
    logic                cfg_we;

    // Configuration registers are plain flops, so a write transfer is
    // always taken; writes to indexes beyond the register list are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tsr_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_RELEASE (MAX_RELEASE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .request_handle  (request_handle),
        .delay_ticks     (delay_ticks),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .released_handle (released_handle),
        .released_index  (released_index),
        .last            (last),
        .sequence_done   (sequence_done)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the timed sequence release block.
`timescale 1ns / 1ps

// The testbench drives command transfers into the block, keeps its own copy of the activity
// tables and the run state, and predicts the releases that every accepted tick causes.
// A monitor compares each result transfer, field by field, with the oldest prediction.
// Both channels idle at random. The configuration registers are only rewritten
// between phases, once every predicted release has arrived and the block has had time
// to finish any tick that releases nothing.
module tb_top;

    localparam int CLK_PERIOD  = 12;
    // Drain wait that covers any tick still in flight.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_CMDS   = 30;
    localparam int TABLE_DEPTH  = tsr_pkg::MAX_ENTRIES_DEF;
    // An index that maps to no register; writes to it must change nothing.
    localparam logic [tsr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd255;

    typedef struct packed {
        tsr_pkg::opcode_t             op;
        logic [tsr_pkg::INDEX_W-1:0]  index;
        logic [tsr_pkg::HANDLE_W-1:0] handle;
        logic [tsr_pkg::DELAY_W-1:0]  delay;
    } seq_cmd_t;

    typedef struct packed {
        logic [tsr_pkg::HANDLE_W-1:0] handle;
        logic [tsr_pkg::INDEX_W-1:0]  index;
        logic                         last;
        logic                         done;
    } release_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [tsr_pkg::OPCODE_W-1:0]   opcode;
    logic [tsr_pkg::INDEX_W-1:0]    entry_index;
    logic [tsr_pkg::HANDLE_W-1:0]   request_handle;
    logic [tsr_pkg::DELAY_W-1:0]    delay_ticks;
    logic                           out_valid;
    logic                           out_ready;
    logic [tsr_pkg::HANDLE_W-1:0]   released_handle;
    logic [tsr_pkg::INDEX_W-1:0]    released_index;
    logic                           last;
    logic                           sequence_done;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data;

    timed_sequence_release dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .request_handle  (request_handle),
        .delay_ticks     (delay_ticks),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .released_handle (released_handle),
        .released_index  (released_index),
        .last            (last),
        .sequence_done   (sequence_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Predicted state of the block: both tables, the run state and the two registers.
    logic [tsr_pkg::HANDLE_W-1:0]  seq_handle [TABLE_DEPTH];
    logic [tsr_pkg::DELAY_W-1:0]   seq_delay [TABLE_DEPTH];
    logic [4:0]                    seq_next;
    logic [tsr_pkg::DELAY_W-1:0]   seq_countdown;
    bit                            seq_running;
    logic [tsr_pkg::CFG_REG_W-1:0] cur_entry_count;
    logic [tsr_pkg::CFG_REG_W-1:0] cur_release_limit;

    // Commands waiting to be driven, and releases predicted but not yet seen.
    seq_cmd_t pending_cmds[$];
    release_t expected_releases[$];

    seq_cmd_t cur_cmd;
    release_t want;
    bit       cmd_active;
    bit       cmd_taken;
    bit       rel_taken;
    bit       cfg_taken;
    int       cmd_gap;
    int       rel_wait;
    int       in_idle_max;
    int       out_idle_max;
    int       cmds_queued;
    int       cmds_accepted;
    int       releases_checked;
    int       reg_writes;
    int       errors;
    int       cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Applies one accepted command to the predicted state and queues the releases that
    // it causes. Only a tick during a run can release anything.
    task automatic predict_releases(input seq_cmd_t cmd);
        int       count;
        int       limit;
        int       n;
        bit       ended;
        release_t rel;
        release_t batch[$];
        n = 0;
        ended = 1'b0;
        case (cmd.op)
            tsr_pkg::OP_LOAD:
            begin
                seq_handle[cmd.index] = cmd.handle;
                seq_delay[cmd.index] = cmd.delay;
            end
            tsr_pkg::OP_ACTIVATE:
            begin
                seq_next = '0;
                seq_countdown = '0;
                seq_running = 1'b1;
            end
            tsr_pkg::OP_ABORT:
            begin
                seq_next = '0;
                seq_countdown = '0;
                seq_running = 1'b0;
            end
            default:
            begin
                if (seq_running)
                begin
                    count = (cur_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_entry_count;
                    limit = cur_release_limit;
                    if (limit > tsr_pkg::MAX_RELEASE_DEF)
                        limit = tsr_pkg::MAX_RELEASE_DEF;
                    if (limit > tsr_pkg::RESULT_CAP)
                        limit = tsr_pkg::RESULT_CAP;
                    // The end of the table is checked before the release limit.
                    while (seq_countdown == 0)
                    begin
                        if (seq_next >= count)
                        begin
                            seq_next = '0;
                            seq_running = 1'b0;
                            ended = 1'b1;
                            break;
                        end
                        if (n >= limit)
                            break;
                        rel = '0;
                        rel.handle = seq_handle[seq_next[3:0]];
                        rel.index = seq_next[3:0];
                        batch = {batch, rel};
                        n++;
                        seq_countdown = seq_delay[seq_next[3:0]];
                        seq_next = seq_next + 1'b1;
                    end
                    if (seq_countdown != 0)
                        seq_countdown = seq_countdown - 1'b1;
                    if (ended && n == 0)
                    begin
                        // A run that ends without a release still reports its end once.
                        rel = '0;
                        rel.done = 1'b1;
                        expected_releases = {expected_releases, rel};
                    end
                    for (int k = 0; k < n; k++)
                    begin
                        rel = batch[k];
                        rel.last = (k == n - 1);
                        rel.done = ended;
                        expected_releases = {expected_releases, rel};
                    end
                end
            end
        endcase
    endtask

    // Command driver: a new command goes out at the falling edge once the drawn gap has
    // passed. If the gap is zero, valid simply stays high into the next command.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_taken)
            begin
                cmd_taken = 1'b0;
                cmd_active = 1'b0;
                cmd_gap = $urandom_range(0, in_idle_max);
            end
            if (!cmd_active)
            begin
                if (cmd_gap > 0)
                    cmd_gap--;
                else if (pending_cmds.size() != 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_active = 1'b1;
                end
            end
            in_valid <= cmd_active;
            opcode <= cur_cmd.op;
            entry_index <= cur_cmd.index;
            request_handle <= cur_cmd.handle;
            delay_ticks <= cur_cmd.delay;
        end
    end

    // Each command is predicted at the edge where its transfer happens.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_releases(cur_cmd);
            cmds_accepted++;
            cmd_taken = 1'b1;
        end
    end

    // Result side: after each transfer, ready drops for a drawn gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rel_taken)
            begin
                rel_taken = 1'b0;
                rel_wait = $urandom_range(0, out_idle_max);
            end
            else if (rel_wait > 0)
                rel_wait--;
            out_ready <= (rel_wait == 0);
        end
    end

    // Monitor: every result transfer must match the oldest predicted release.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            rel_taken = 1'b1;
            releases_checked++;
            if (expected_releases.size() == 0)
            begin
                errors++;
                $display({"%0t: unexpected release: expected none, actual handle %h",
                          " index %0d last %b done %b"},
                         $time, released_handle, released_index, last, sequence_done);
            end
            else
            begin
                want = expected_releases.pop_front();
                if (released_handle !== want.handle || released_index !== want.index ||
                    last !== want.last || sequence_done !== want.done)
                begin
                    errors++;
                    $display({"%0t: release mismatch: expected handle %h index %0d last %b",
                              " done %b, actual handle %h index %0d last %b done %b"},
                             $time, want.handle, want.index, want.last, want.done,
                             released_handle, released_index, last, sequence_done);
                end
            end
        end
    end

    // Register writes take effect in the prediction at their own transfer.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == tsr_pkg::REG_ENTRY_COUNT)
                cur_entry_count = cfg_data[tsr_pkg::CFG_REG_W-1:0];
            else if (cfg_index == tsr_pkg::REG_RELEASE_LIMIT)
                cur_release_limit = cfg_data[tsr_pkg::CFG_REG_W-1:0];
            reg_writes++;
            cfg_taken = 1'b1;
        end
    end

    // The run is bounded; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Only the low five bits matter, so the upper bits carry random noise.
    task automatic write_reg(input logic [tsr_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ($urandom() & ~32'h1F) | (value & 32'h1F);
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_taken = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_cmd(input tsr_pkg::opcode_t op,
                             input logic [tsr_pkg::INDEX_W-1:0] idx,
                             input logic [tsr_pkg::HANDLE_W-1:0] handle,
                             input logic [tsr_pkg::DELAY_W-1:0] delay);
        seq_cmd_t cmd;
        cmd.op = op;
        cmd.index = idx;
        cmd.handle = handle;
        cmd.delay = delay;
        pending_cmds = {pending_cmds, cmd};
        cmds_queued++;
    endtask

    // Loads mostly carry short delays so that runs keep moving; a rare full-width delay
    // parks a run until the next activate or abort. Unused fields of other commands are
    // random.
    task automatic queue_random(input tsr_pkg::opcode_t op);
        logic [tsr_pkg::DELAY_W-1:0] delay;
        delay = $urandom();
        if (op == tsr_pkg::OP_LOAD && $urandom_range(0, 19) != 0)
            delay = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        queue_cmd(op, tsr_pkg::INDEX_W'($urandom_range(0, 15)),
                  tsr_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF)), delay);
    endtask

    // Mostly well-formed runs: a few loads, activate, a burst of ticks with the odd load
    // in between, sometimes an abort. The rest is single commands of any kind.
    task automatic fill_phase(input int quota);
        int first;
        int n;
        first = cmds_queued;
        while (cmds_queued - first < quota)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n = $urandom_range(0, 3);
                repeat (n) queue_random(tsr_pkg::OP_LOAD);
                queue_random(tsr_pkg::OP_ACTIVATE);
                n = $urandom_range(2, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_random(tsr_pkg::OP_LOAD);
                    queue_random(tsr_pkg::OP_TICK);
                end
                if ($urandom_range(0, 2) == 0)
                    queue_random(tsr_pkg::OP_ABORT);
            end
            else
                queue_random(tsr_pkg::opcode_t'($urandom_range(0, 3)));
        end
    endtask

    // Waits until every command has gone in and every release has come out, then lets
    // any tick that releases nothing run to its end.
    task automatic wait_idle();
        while (cmds_accepted != cmds_queued || expected_releases.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 16;
            3: return 31;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    initial
    begin
        int ec;
        int rl;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = tsr_pkg::OP_TICK;
        entry_index = '0;
        request_handle = '0;
        delay_ticks = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_cmd = '0;
        seq_next = '0;
        seq_countdown = '0;
        seq_running = 1'b0;
        cur_entry_count = '0;
        cur_release_limit = tsr_pkg::RELEASE_LIMIT_RST;
        in_idle_max = 4;
        out_idle_max = 4;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings (no entries, full release limit).
        // A tick and an abort while no run is active do nothing. Then every entry gets
        // loaded, with the handle extremes on entries 0 and 1, a two-tick delay on entry 5
        // and the largest delay on entry 15. With zero entries configured, the first
        // tick of a run ends it without a release.
        queue_cmd(tsr_pkg::OP_TICK, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(tsr_pkg::OP_ABORT, 4'h0, 16'h0000, 32'h0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            queue_cmd(tsr_pkg::OP_LOAD, tsr_pkg::INDEX_W'(i),
                      (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF
                                          : tsr_pkg::HANDLE_W'(16'h1000 + i * 16'h0111),
                      (i == 5) ? 32'd2 : (i == 15) ? 32'hFFFF_FFFF : 32'd0);
        queue_cmd(tsr_pkg::OP_ACTIVATE, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_TICK, 4'h0, 16'h0, 32'h0);
        wait_idle();

        // All sixteen entries: a tick releases entries 0 to 5 and waits on the delay, an
        // activate in the middle of the run restarts it, the next tick releases 0 to 5
        // again, a tick spends the last delay tick, the next releases the rest and parks
        // on the largest delay, and an abort ends the run.
        write_reg(tsr_pkg::REG_ENTRY_COUNT, 16);
        queue_cmd(tsr_pkg::OP_ACTIVATE, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_TICK, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_ACTIVATE, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_TICK, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_TICK, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_TICK, 4'h0, 16'h0, 32'h0);
        queue_cmd(tsr_pkg::OP_ABORT, 4'h0, 16'h0, 32'h0);
        wait_idle();

        // Random phases. The first few pin both registers to their extremes, including a
        // limit of zero with and without an empty table; later ones draw freely.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ec = 16;
                    rl = 1;
                end
                1:
                begin
                    ec = 31;
                    rl = 31;
                end
                2:
                begin
                    ec = 1;
                    rl = 0;
                end
                3:
                begin
                    ec = 0;
                    rl = 0;
                end
                4:
                begin
                    ec = 16;
                    rl = 16;
                end
                default:
                begin
                    ec = pick_reg_value();
                    rl = pick_reg_value();
                end
            endcase
            write_reg(tsr_pkg::REG_ENTRY_COUNT, ec);
            write_reg(tsr_pkg::REG_RELEASE_LIMIT, rl);
            if (p == 5)
                write_reg(REG_UNMAPPED, $urandom_range(0, 31));
            // Some phases run without idle cycles on one side or the other.
            in_idle_max = (p % 3 == 2) ? 0 : 4;
            out_idle_max = (p % 4 == 3) ? 0 : 4;
            fill_phase(PHASE_CMDS);
            wait_idle();
        end

        $display("Checked %0d releases from %0d commands across %0d register writes.",
                 releases_checked, cmds_accepted, reg_writes);
        $display("Table sizes and release limits went from 0 to 31, with and without stalls.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
